// ----- hw/rtl/state_change_notifier_with_retry_unit_macros.svh -----
// Assertion macros shared by the notifier RTL.
// Included by scn_dpath, the module that carries concurrent checks; no other dependencies.
`ifndef STATE_CHANGE_NOTIFIER_WITH_RETRY_UNIT_MACROS_SVH
`define STATE_CHANGE_NOTIFIER_WITH_RETRY_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// cond must hold at every clock edge outside reset
`define SCN_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("scn: invariant violated");

// trig implies cond in the same cycle
`define SCN_ASSERT_IMP(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("scn: implication violated");

// trig implies cond in the next cycle
`define SCN_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("scn: next-cycle implication violated");

`else

`define SCN_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define SCN_ASSERT_IMP(label, clk, rst_n, trig, cond)
`define SCN_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

// ----- hw/rtl/scn_pkg.sv -----
// Shared types and constants of the state change notifier.
// No dependencies; imported by the top level, scn_ctrl and scn_dpath.
package scn_pkg;

    // client table size and derived widths
    localparam int MAX_CLIENTS = 16;
    localparam int IDX_W       = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);

    localparam logic [7:0]  ADDR_INVALID     = 8'hff;
    localparam logic [7:0]  OWN_ADDR_RST     = 8'd0;
    localparam logic [15:0] RESP_TIMEOUT_RST = 16'd100;
    localparam logic [15:0] CYCLE_DELAY_RST  = 16'd200;
    localparam logic [15:0] ROUND_TIMEOUT_RST = 16'd10000;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_OWN_ADDR      = 2'd0,
        REG_RESP_TIMEOUT  = 2'd1,
        REG_CYCLE_DELAY   = 2'd2,
        REG_ROUND_TIMEOUT = 2'd3
    } t_reg;

    // item kinds
    typedef enum logic [1:0] {
        KIND_POLL    = 2'd0,
        KIND_CONFIRM = 2'd1,
        KIND_LOAD    = 2'd2
    } t_kind;

    // per-client notify status
    typedef enum logic [1:0] {
        ST_INIT = 2'd0,
        ST_WAIT = 2'd1,
        ST_OK   = 2'd2
    } t_status;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_P_CHECK,
        S_P_EVAL,
        S_P_SCAN,
        S_P_FINISH,
        S_C_SCAN,
        S_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;        // capture the accepted item
        logic load;         // write a list slot
        logic poll_change;  // restart round if switch state changed
        logic clr_delay;    // drop the pending wrap delay
        logic end_round;    // stop the round
        logic p_eval;       // serve the current client
        logic scan_start;   // begin round-robin search after current client
        logic scan_step;    // move search to the next entry
        logic scan_hit;     // search found an unconfirmed client
        logic p_finish;     // apply round timeout
        logic c_start;      // begin confirmation search at entry 0
        logic c_step;       // move confirmation search to the next entry
        logic c_hit;        // confirmation search matched a waiting client
        logic res_load;     // move result into the output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       count_zero;
        logic       cfm_ok;
        logic       round_valid;
        logic       dly_pending;
        logic       dly_elapsed;
        logic       cur_in_range;
        logic       eval_advance;
        logic       scan_found;
        logic       scan_last;
        logic       c_match;
        logic       c_last;
    } t_sts;

endpackage

// ----- hw/rtl/scn_in_if.sv -----
// Input item channel of the state change notifier.
// Valid/ready handshake with the item fields; no dependencies.
interface scn_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] time_ms;
    logic [1:0]  switch_value;
    logic        bus_ready;
    logic [7:0]  target_addr;
    logic [7:0]  source_addr;
    logic [1:0]  echoed_value;
    logic [3:0]  slot_index;

    modport source (
        output valid, kind, time_ms, switch_value, bus_ready,
        output target_addr, source_addr, echoed_value, slot_index,
        input  ready
    );
    modport sink (
        input  valid, kind, time_ms, switch_value, bus_ready,
        input  target_addr, source_addr, echoed_value, slot_index,
        output ready
    );
endinterface

// ----- hw/rtl/scn_out_if.sv -----
// Result item channel of the state change notifier.
// Valid/ready handshake with the result fields; no dependencies.
interface scn_out_if;
    logic       valid;
    logic       ready;
    logic       send_request;
    logic [7:0] request_receiver;
    logic [7:0] request_sender;
    logic [1:0] request_value;
    logic       round_active;
    logic       client_confirmed;

    modport source (
        output valid, send_request, request_receiver, request_sender,
        output request_value, round_active, client_confirmed,
        input  ready
    );
    modport sink (
        input  valid, send_request, request_receiver, request_sender,
        input  request_value, round_active, client_confirmed,
        output ready
    );
endinterface

// ----- hw/rtl/scn_cfg_if.sv -----
// Configuration write channel of the state change notifier.
// Valid/ready handshake with register index and write data; no dependencies.
interface scn_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/state_change_notifier_with_retry_unit.sv -----
// State change notifier with retry: top level. Uses scn_pkg, scn_ctrl, scn_dpath.
// Each item (load, confirmation or poll; client count up to 16) runs to its result
// before the next one is accepted; a new item is taken the cycle after its result is
// registered. The scan steps one table entry per cycle.
// Reset (synchronous, active low) empties the list, ends any round, sets all
// clients to init and loads the register defaults; no clearing pass is needed.
module state_change_notifier_with_retry_unit (
    input logic  i_clk,
    input logic  i_rst_n,
    scn_in_if.sink   i_in,
    scn_out_if.source o_out,
    scn_cfg_if.sink  i_cfg
);
    import scn_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    scn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    scn_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_kind             (i_in.kind),
        .i_time_ms          (i_in.time_ms),
        .i_switch_value     (i_in.switch_value),
        .i_bus_ready        (i_in.bus_ready),
        .i_target_addr      (i_in.target_addr),
        .i_source_addr      (i_in.source_addr),
        .i_echoed_value     (i_in.echoed_value),
        .i_slot_index       (i_in.slot_index),
        .i_cfg_we           (i_cfg.valid),
        .i_cfg_index        (i_cfg.index),
        .i_cfg_data         (i_cfg.data),
        .o_send_request     (o_out.send_request),
        .o_request_receiver (o_out.request_receiver),
        .o_request_sender   (o_out.request_sender),
        .o_request_value    (o_out.request_value),
        .o_round_active     (o_out.round_active),
        .o_client_confirmed (o_out.client_confirmed)
    );

    // handshakes; configuration writes are always taken
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign i_cfg.ready = 1'b1;
endmodule

// ----- hw/rtl/scn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the client address and request time tables.
module scn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/scn_ctrl.sv -----
// Sequencing state machine of the state change notifier.
// Depends on scn_pkg; drives t_cmd to the datapath, reads its t_sts.
module scn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  scn_pkg::t_sts i_sts,
    output scn_pkg::t_cmd o_cmd
);
    import scn_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.kind)
                    KIND_POLL: begin
                        if (i_sts.count_zero) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.poll_change = 1'b1;
                            n_state           = S_P_CHECK;
                        end
                    end
                    KIND_CONFIRM: begin
                        if (i_sts.cfm_ok) begin
                            o_cmd.c_start = 1'b1;
                            n_state       = S_C_SCAN;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    KIND_LOAD: begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_P_CHECK: begin
                if (!i_sts.round_valid) begin
                    n_state = S_DONE;
                end else if (i_sts.dly_pending && !i_sts.dly_elapsed) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.clr_delay = 1'b1;
                    if (!i_sts.cur_in_range) begin
                        o_cmd.end_round = 1'b1;
                        n_state         = S_DONE;
                    end else begin
                        n_state = S_P_EVAL;
                    end
                end
            end
            S_P_EVAL: begin
                o_cmd.p_eval = 1'b1;
                if (i_sts.eval_advance) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_P_SCAN;
                end else begin
                    n_state = S_P_FINISH;
                end
            end
            S_P_SCAN: begin
                if (i_sts.scan_found) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state        = S_P_FINISH;
                end else if (i_sts.scan_last) begin
                    o_cmd.end_round = 1'b1;
                    n_state         = S_P_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_P_FINISH: begin
                o_cmd.p_finish = 1'b1;
                n_state        = S_DONE;
            end
            S_C_SCAN: begin
                if (i_sts.c_match) begin
                    o_cmd.c_hit = 1'b1;
                    n_state     = S_DONE;
                end else if (i_sts.c_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.c_step = 1'b1;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ----- hw/rtl/scn_dpath.sv -----
// Datapath of the state change notifier: client tables, round state, result.
// Depends on scn_pkg, scn_ram and the assertion macro header.
`include "state_change_notifier_with_retry_unit_macros.svh"

module scn_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  scn_pkg::t_cmd i_cmd,
    output scn_pkg::t_sts o_sts,
    // item fields
    input  logic [1:0]    i_kind,
    input  logic [15:0]   i_time_ms,
    input  logic [1:0]    i_switch_value,
    input  logic          i_bus_ready,
    input  logic [7:0]    i_target_addr,
    input  logic [7:0]    i_source_addr,
    input  logic [1:0]    i_echoed_value,
    input  logic [3:0]    i_slot_index,
    // configuration writes
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    // result fields
    output logic          o_send_request,
    output logic [7:0]    o_request_receiver,
    output logic [7:0]    o_request_sender,
    output logic [1:0]    o_request_value,
    output logic          o_round_active,
    output logic          o_client_confirmed
);
    import scn_pkg::*;

    // latched item
    logic [1:0]  r_kind;
    logic [15:0] r_time;
    logic [1:0]  r_sw;
    logic        r_bus_ready;
    logic [7:0]  r_target;
    logic [7:0]  r_source;
    logic [1:0]  r_echo;
    logic [3:0]  r_slot;

    // configuration
    logic [7:0]  r_own;
    logic [15:0] r_resp_to;
    logic [15:0] r_cycle_dly;
    logic [15:0] r_round_to;

    // round state
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_cur;
    logic             r_valid;
    logic [1:0]       r_last;
    logic [15:0]      r_change;
    logic             r_dly_pend;
    logic [15:0]      r_dly_start;
    t_status          r_status [MAX_CLIENTS];

    // search pointers
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_scan_cnt;

    // result being built
    logic        r_res_send;
    logic [7:0]  r_res_recv;
    logic [7:0]  r_res_sender;
    logic [1:0]  r_res_value;
    logic        r_res_confirmed;

    // RAM ports
    logic [IDX_W-1:0] addr_raddr;
    logic [7:0]       addr_rdata;
    logic [15:0]      rt_rdata;
    logic             rt_we;

    // derived values
    t_status          cur_status;
    t_status          idx_status;
    t_status          n_cur_status;
    logic             changed;
    logic [CNT_W-1:0] load_base;
    logic [IDX_W-1:0] load_pos;
    logic             load_ok;
    logic [15:0]      resp_age;
    logic [15:0]      dly_age;
    logic [15:0]      round_age;
    logic             resp_expired;
    logic             eval_advance;
    logic             round_over;
    logic [IDX_W-1:0] cur_wrap;
    logic [IDX_W-1:0] idx_wrap;
    logic             cfm_echo_ok;

    assign cur_status  = r_status[r_cur];
    assign idx_status  = r_status[r_idx];
    assign changed     = (r_sw != r_last);
    assign cfm_echo_ok = (r_echo == r_sw);

    // list load position; slot 0 restarts the list
    assign load_base = (r_slot == '0) ? '0 : r_count;
    assign load_pos  = load_base[IDX_W-1:0];
    assign load_ok   = (r_source != ADDR_INVALID) && (load_base < CNT_W'(MAX_CLIENTS));

    // wrapping time differences
    assign resp_age     = r_time - rt_rdata;
    assign dly_age      = r_time - r_dly_start;
    assign round_age    = r_time - r_change;
    assign resp_expired = (resp_age >= r_resp_to);
    assign round_over   = (round_age > r_round_to);

    // round-robin successors
    assign cur_wrap = ((CNT_W'(r_cur) + CNT_W'(1)) == r_count) ? '0 : r_cur + IDX_W'(1);
    assign idx_wrap = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count) ? '0 : r_idx + IDX_W'(1);

    // serving the current client
    always_comb begin
        n_cur_status = cur_status;
        eval_advance = 1'b1;
        case (cur_status)
            ST_INIT: begin
                eval_advance = r_bus_ready;
                if (r_bus_ready) begin
                    n_cur_status = ST_WAIT;
                end
            end
            ST_WAIT: begin
                eval_advance = !resp_expired;
                if (resp_expired) begin
                    n_cur_status = ST_INIT;
                end
            end
            default: begin
                eval_advance = 1'b1;
            end
        endcase
    end

    assign rt_we = i_cmd.p_eval && (cur_status == ST_INIT) && r_bus_ready;

    // address table read: entry 0 to open a confirmation search, the next
    // entry while stepping it, otherwise the current client
    always_comb begin
        if (i_cmd.c_start) begin
            addr_raddr = '0;
        end else if (i_cmd.c_step) begin
            addr_raddr = r_idx + IDX_W'(1);
        end else begin
            addr_raddr = r_cur;
        end
    end

    scn_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CLIENTS)
    ) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && load_ok),
        .i_waddr (load_pos),
        .i_wdata (r_source),
        .i_raddr (addr_raddr),
        .o_rdata (addr_rdata)
    );

    scn_ram #(
        .WIDTH (16),
        .DEPTH (MAX_CLIENTS)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (rt_we),
        .i_waddr (r_cur),
        .i_wdata (r_time),
        .i_raddr (r_cur),
        .o_rdata (rt_rdata)
    );

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind      <= i_kind;
            r_time      <= i_time_ms;
            r_sw        <= i_switch_value;
            r_bus_ready <= i_bus_ready;
            r_target    <= i_target_addr;
            r_source    <= i_source_addr;
            r_echo      <= i_echoed_value;
            r_slot      <= i_slot_index;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own       <= OWN_ADDR_RST;
            r_resp_to   <= RESP_TIMEOUT_RST;
            r_cycle_dly <= CYCLE_DELAY_RST;
            r_round_to  <= ROUND_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OWN_ADDR:      r_own       <= i_cfg_data[7:0];
                REG_RESP_TIMEOUT:  r_resp_to   <= i_cfg_data;
                REG_CYCLE_DELAY:   r_cycle_dly <= i_cfg_data;
                REG_ROUND_TIMEOUT: r_round_to  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // round state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cur       <= '0;
            r_valid     <= 1'b0;
            r_last      <= '0;
            r_change    <= '0;
            r_dly_pend  <= 1'b0;
            r_dly_start <= '0;
        end else begin
            if (i_cmd.load) begin
                r_count <= load_ok ? load_base + CNT_W'(1) : load_base;
            end
            if (i_cmd.poll_change && changed) begin
                r_change   <= r_time;
                r_cur      <= '0;
                r_valid    <= 1'b1;
                r_dly_pend <= 1'b0;
                r_last     <= r_sw;
            end
            if (i_cmd.clr_delay) begin
                r_dly_pend <= 1'b0;
            end
            if (i_cmd.end_round) begin
                r_valid <= 1'b0;
            end
            // wrapping back to an earlier or the same client arms the cycle delay
            if (i_cmd.scan_hit) begin
                r_cur <= r_idx;
                if (r_idx <= r_cur) begin
                    r_dly_pend  <= 1'b1;
                    r_dly_start <= r_time;
                end
            end
            if (i_cmd.p_finish && round_over) begin
                r_valid <= 1'b0;
            end
        end
    end

    // per-client status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CLIENTS; i++) begin
                r_status[i] <= ST_INIT;
            end
        end else begin
            for (int i = 0; i < MAX_CLIENTS; i++) begin
                if (i_cmd.poll_change && changed) begin
                    r_status[i] <= ST_INIT;
                end else if (i_cmd.load && load_ok && (load_pos == IDX_W'(i))) begin
                    r_status[i] <= ST_INIT;
                end else if (i_cmd.p_eval && (r_cur == IDX_W'(i))) begin
                    r_status[i] <= n_cur_status;
                end else if (i_cmd.c_hit && cfm_echo_ok && (r_idx == IDX_W'(i))) begin
                    r_status[i] <= ST_OK;
                end
            end
        end
    end

    // search pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_scan_cnt <= '0;
        end else begin
            if (i_cmd.scan_start) begin
                r_idx      <= cur_wrap;
                r_scan_cnt <= '0;
            end else if (i_cmd.scan_step) begin
                r_idx      <= idx_wrap;
                r_scan_cnt <= r_scan_cnt + IDX_W'(1);
            end else if (i_cmd.c_start) begin
                r_idx <= '0;
            end else if (i_cmd.c_step) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // result build-up
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_res_send      <= 1'b0;
            r_res_recv      <= '0;
            r_res_sender    <= '0;
            r_res_value     <= '0;
            r_res_confirmed <= 1'b0;
        end else begin
            if (rt_we) begin
                r_res_send   <= 1'b1;
                r_res_recv   <= addr_rdata;
                r_res_sender <= r_own;
                r_res_value  <= r_sw;
            end
            if (i_cmd.c_hit && cfm_echo_ok) begin
                r_res_confirmed <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_send_request     <= r_res_send;
            o_request_receiver <= r_res_recv;
            o_request_sender   <= r_res_sender;
            o_request_value    <= r_res_value;
            o_round_active     <= r_valid;
            o_client_confirmed <= r_res_confirmed;
        end
    end

    // status to controller
    always_comb begin
        o_sts              = '0;
        o_sts.kind         = r_kind;
        o_sts.count_zero   = (r_count == '0);
        o_sts.cfm_ok       = (r_target == r_own) && (r_count != '0);
        o_sts.round_valid  = r_valid;
        o_sts.dly_pending  = r_dly_pend;
        o_sts.dly_elapsed  = (dly_age >= r_cycle_dly);
        o_sts.cur_in_range = (CNT_W'(r_cur) < r_count);
        o_sts.eval_advance = eval_advance;
        o_sts.scan_found   = (idx_status != ST_OK);
        o_sts.scan_last    = ((CNT_W'(r_scan_cnt) + CNT_W'(1)) == r_count);
        o_sts.c_match      = (addr_rdata == r_source) && (idx_status == ST_WAIT);
        o_sts.c_last       = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    end

    // checks
    `SCN_ASSERT_ALWAYS(a_count_max, i_clk, i_rst_n, r_count <= CNT_W'(MAX_CLIENTS))
    `SCN_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n, i_cmd.scan_step, (CNT_W'(r_scan_cnt) + CNT_W'(1)) < r_count)
    `SCN_ASSERT_IMP(a_send_excl, i_clk, i_rst_n, r_res_send, !r_res_confirmed)
    `SCN_ASSERT_NEXT(a_hit_marks, i_clk, i_rst_n, i_cmd.c_hit && cfm_echo_ok, r_res_confirmed)
endmodule
